// ----- design/ipt_pkg.sv -----
// Shared types, sizes and codes of the interval partition table.
package ipt_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int POS_WIDTH    = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int TOTAL_WIDTH  = POS_WIDTH + 1;
	localparam int IDX_WIDTH    = $clog2(MAX_SEGMENTS);
	localparam int CNT_WIDTH    = $clog2(MAX_SEGMENTS + 1);
	localparam int CFG_IDX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH = (TOTAL_WIDTH > DATA_WIDTH) ? TOTAL_WIDTH : DATA_WIDTH;

	typedef logic [POS_WIDTH-1:0]   pos_t;
	typedef logic [DATA_WIDTH-1:0]  data_t;
	typedef logic [TOTAL_WIDTH-1:0] total_t;
	typedef logic [IDX_WIDTH-1:0]   idx_t;
	typedef logic [CNT_WIDTH-1:0]   cnt_t;
	typedef logic [1:0]             req_type_t;
	typedef logic [1:0]             status_t;

	localparam req_type_t REQ_QUERY  = 2'd0;
	localparam req_type_t REQ_SPLIT  = 2'd1;
	localparam req_type_t REQ_REMOVE = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_BASE  = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_TOTAL_SIZE   = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_INITIAL_DATA = 1'd1;

	localparam total_t TOTAL_SIZE_RESET = total_t'(65536);

	typedef struct packed {
		pos_t  start;
		data_t data;
	} entry_t;

	typedef struct packed {
		pos_t    seg_left;
		total_t  seg_right;
		data_t   seg_data;
		status_t status;
	} rsp_t;

	typedef struct packed {
		total_t total_size;
		data_t  initial_data;
		logic   reinit;
	} tbl_cfg_t;

endpackage

// ----- design/ipt_req_if.sv -----
// Request channel: request type and position.
interface ipt_req_if;
	logic               valid;
	logic               ready;
	ipt_pkg::req_type_t req_type;
	ipt_pkg::pos_t      pos;

	modport source (output valid, output req_type, output pos, input ready);
	modport sink (input valid, input req_type, input pos, output ready);
endinterface

// ----- design/ipt_rsp_if.sv -----
// Response channel: holding segment bounds, data and status.
interface ipt_rsp_if;
	logic             valid;
	logic             ready;
	ipt_pkg::pos_t    seg_left;
	ipt_pkg::total_t  seg_right;
	ipt_pkg::data_t   seg_data;
	ipt_pkg::status_t status;

	modport source (output valid, output seg_left, output seg_right, output seg_data,
		output status, input ready);
	modport sink (input valid, input seg_left, input seg_right, input seg_data,
		input status, output ready);
endinterface

// ----- design/interval_partition_table_unit.sv -----
// Interval partition table: config registers, response buffer and sequencer.
//
// Keeps 0..total_size as a sorted list of segment starts, each with a data word.
// req channel: one beat carries req_type (query, split, remove) and pos.
// rsp channel: one beat per request with seg_left, seg_right, seg_data, status.
// Config port: cfg_we/cfg_idx/cfg_wdata; any write reloads the table to one
// segment at 0 holding initial_data. Write only while no request is in flight.
// Operation: the holder is found by a linear scan through the table RAM, one entry
// per cycle on the single comparator; the scan stops at the first start above
// pos. A query or a rejected request is answered after the scan. A split then
// shifts the entries above the holding segment up one place and writes the new
// start (no shift when pos is in the last segment); a remove shifts them down
// one place over the removed entry (no shift when the last segment goes).
// A position out of range is answered without a scan.
// One request is in work at a time; req.ready is low while it runs.
// The response sits in an output register, so a new request is taken while the
// previous response waits; if the receiver stalls, the next finished response
// waits in the sequencer and req.ready stays low.
// Reset: total_size 65536, initial_data 0, table of one segment; no clearing pass.
module interval_partition_table_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	ipt_req_if.sink                               req,
	ipt_rsp_if.source                             rsp,
	input  logic                                  cfg_we,
	input  logic [ipt_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx,
	input  logic [ipt_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata
);
	ipt_pkg::total_t   total_size_q;
	ipt_pkg::data_t    initial_data_q;
	ipt_pkg::tbl_cfg_t cfg;
	logic              res_valid;
	logic              res_ready;
	ipt_pkg::rsp_t     res;
	logic              out_valid_q;
	ipt_pkg::rsp_t     out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q   <= ipt_pkg::TOTAL_SIZE_RESET;
			initial_data_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ipt_pkg::REG_TOTAL_SIZE:
					total_size_q <= cfg_wdata[ipt_pkg::TOTAL_WIDTH-1:0];
				ipt_pkg::REG_INITIAL_DATA:
					initial_data_q <= cfg_wdata[ipt_pkg::DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{total_size: total_size_q, initial_data: initial_data_q, reinit: cfg_we};

	ipt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_type (req.req_type),
		.req_pos  (req.pos),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.seg_left  = out_q.seg_left;
	assign rsp.seg_right = out_q.seg_right;
	assign rsp.seg_data  = out_q.seg_data;
	assign rsp.status    = out_q.status;

`ifndef SYNTHESIS
	// an accepted request drops req.ready in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken back to back");

	// an in-range answer always names a non-empty segment
	a_seg_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ipt_pkg::ST_RANGE |-> {1'b0, rsp.seg_left} < rsp.seg_right)
		else $error("empty or inverted segment reported");

	// out-of-range answers carry zero fields
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ipt_pkg::ST_RANGE |->
		rsp.seg_left == '0 && rsp.seg_right == '0 && rsp.seg_data == '0)
		else $error("out-of-range answer with nonzero fields");
`endif
endmodule

// ----- design/ipt_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ipt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ----- design/ipt_ctrl.sv -----
// Sequencer: linear scan with one comparator, then one-entry-per-cycle table shift.
module ipt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  ipt_pkg::tbl_cfg_t  cfg,
	input  logic               req_valid,
	output logic               req_ready,
	input  ipt_pkg::req_type_t req_type,
	input  ipt_pkg::pos_t      req_pos,
	output logic               res_valid,
	input  logic               res_ready,
	output ipt_pkg::rsp_t      res
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0]         state_q;
	ipt_pkg::req_type_t type_q;
	ipt_pkg::pos_t      pos_q;
	ipt_pkg::cnt_t      cnt_q;
	ipt_pkg::cnt_t      ptr_q;
	logic               dir_up_q;
	logic               pend_s1;
	ipt_pkg::idx_t      idx_s1;
	ipt_pkg::idx_t      hold_idx_q;
	ipt_pkg::pos_t      hold_start_q;
	ipt_pkg::data_t     hold_data_q;
	ipt_pkg::pos_t      prev_start_q;
	ipt_pkg::data_t     prev_data_q;
	logic               nxt_found_q;
	ipt_pkg::pos_t      nxt_start_q;
	ipt_pkg::rsp_t      res_q;

	logic               ram_we;
	ipt_pkg::idx_t      ram_wr_addr;
	ipt_pkg::entry_t    ram_wr_data;
	ipt_pkg::idx_t      ram_rd_addr;
	ipt_pkg::entry_t    ram_rd_data;

	logic               issue;
	ipt_pkg::cnt_t      hp1;
	ipt_pkg::total_t    right;

	// entry 0 (start 0, initial data) is held outside the RAM; RAM keeps entries 1..count-1
	ipt_ram #(
		.WIDTH($bits(ipt_pkg::entry_t)),
		.DEPTH(ipt_pkg::MAX_SEGMENTS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	assign hp1   = ipt_pkg::cnt_t'(hold_idx_q) + ipt_pkg::cnt_t'(1);
	assign right = nxt_found_q ? {1'b0, nxt_start_q} : cfg.total_size;

	always_comb begin
		issue = 1'b0;
		case (state_q)
			S_SCAN:  issue = (ptr_q < cnt_q) && !nxt_found_q;
			S_SHIFT: issue = dir_up_q ? (ptr_q >= hp1) : (ptr_q < cnt_q);
			default: issue = 1'b0;
		endcase
	end

	assign ram_rd_addr = ptr_q[ipt_pkg::IDX_WIDTH-1:0];

	always_comb begin
		ram_we      = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = ram_rd_data;
		if (state_q == S_SHIFT && pend_s1) begin
			ram_we      = 1'b1;
			ram_wr_addr = dir_up_q ? ipt_pkg::idx_t'(idx_s1 + 1'b1)
				: ipt_pkg::idx_t'(idx_s1 - 1'b1);
		end else if (state_q == S_FILL) begin
			ram_we      = 1'b1;
			ram_wr_addr = ipt_pkg::idx_t'(hold_idx_q + 1'b1);
			ram_wr_data = '{start: pos_q, data: hold_data_q};
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= ipt_pkg::cnt_t'(1);
			pend_s1     <= 1'b0;
			nxt_found_q <= 1'b0;
			dir_up_q    <= 1'b0;
			ptr_q       <= '0;
			hold_idx_q  <= '0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				idx_s1 <= ram_rd_addr;
				ptr_q  <= (state_q == S_SHIFT && dir_up_q) ? ipt_pkg::cnt_t'(ptr_q - 1'b1)
					: ipt_pkg::cnt_t'(ptr_q + 1'b1);
			end
			if (cfg.reinit) begin
				cnt_q <= ipt_pkg::cnt_t'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						type_q       <= req_type;
						pos_q        <= req_pos;
						hold_idx_q   <= '0;
						hold_start_q <= '0;
						hold_data_q  <= cfg.initial_data;
						nxt_found_q  <= 1'b0;
						ptr_q        <= ipt_pkg::cnt_t'(1);
						if ({1'b0, req_pos} >= cfg.total_size) begin
							res_q   <= '{seg_left: '0, seg_right: '0, seg_data: '0,
								status: ipt_pkg::ST_RANGE};
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// table is sorted: entries at or below pos advance the holder,
					// the first one above it is the right bound
					if (pend_s1 && !nxt_found_q) begin
						if (ram_rd_data.start <= pos_q) begin
							prev_start_q <= hold_start_q;
							prev_data_q  <= hold_data_q;
							hold_idx_q   <= idx_s1;
							hold_start_q <= ram_rd_data.start;
							hold_data_q  <= ram_rd_data.data;
						end else begin
							nxt_found_q <= 1'b1;
							nxt_start_q <= ram_rd_data.start;
						end
					end
					if (!issue && !pend_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (type_q)
						ipt_pkg::REQ_SPLIT: begin
							if (hold_start_q == pos_q) begin
								res_q   <= '{seg_left: hold_start_q, seg_right: right,
									seg_data: hold_data_q, status: ipt_pkg::ST_OK};
								state_q <= S_RESP;
							end else if (cnt_q == ipt_pkg::cnt_t'(ipt_pkg::MAX_SEGMENTS)) begin
								res_q   <= '{seg_left: hold_start_q, seg_right: right,
									seg_data: hold_data_q, status: ipt_pkg::ST_FULL};
								state_q <= S_RESP;
							end else begin
								res_q    <= '{seg_left: pos_q, seg_right: right,
									seg_data: hold_data_q, status: ipt_pkg::ST_OK};
								dir_up_q <= 1'b1;
								ptr_q    <= ipt_pkg::cnt_t'(cnt_q - 1'b1);
								state_q  <= (hp1 == cnt_q) ? S_FILL : S_SHIFT;
							end
						end
						ipt_pkg::REQ_REMOVE: begin
							if (hold_idx_q == '0) begin
								res_q   <= '{seg_left: hold_start_q, seg_right: right,
									seg_data: hold_data_q, status: ipt_pkg::ST_BASE};
								state_q <= S_RESP;
							end else begin
								res_q    <= '{seg_left: prev_start_q, seg_right: right,
									seg_data: prev_data_q, status: ipt_pkg::ST_OK};
								dir_up_q <= 1'b0;
								ptr_q    <= hp1;
								state_q  <= S_SHIFT;
							end
						end
						default: begin
							res_q   <= '{seg_left: hold_start_q, seg_right: right,
								seg_data: hold_data_q, status: ipt_pkg::ST_OK};
							state_q <= S_RESP;
						end
					endcase
				end
				S_SHIFT: begin
					if (!issue && !pend_s1) begin
						if (dir_up_q) begin
							state_q <= S_FILL;
						end else begin
							cnt_q   <= ipt_pkg::cnt_t'(cnt_q - 1'b1);
							state_q <= S_RESP;
						end
					end
				end
				S_FILL: begin
					cnt_q   <= ipt_pkg::cnt_t'(cnt_q + 1'b1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the interval partition table: directed table, then random phases.
module tb_top;
	import ipt_pkg::*;

	localparam int        CYCLE_LIMIT = 1000000;
	localparam int        DRAIN_CYCLES = 200;
	localparam int        PHASES = 8;
	localparam req_type_t REQ_SPARE = 2'd3;

	typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		req_type_t                 rt;
		logic [CFG_IDX_WIDTH-1:0]  idx;
		logic [CFG_DATA_WIDTH-1:0] val;
		rsp_t                      want;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

	ipt_req_if req_ch ();
	ipt_rsp_if rsp_ch ();

	interval_partition_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// table mirror
	pos_t   seg_start [MAX_SEGMENTS];
	data_t  seg_word [MAX_SEGMENTS];
	int     seg_count;
	total_t tot_size;
	data_t  init_word;

	rsp_t   pending_rsp [$];
	row_t   dir_tab [$];
	bit     quiet;
	bit     want_typed;
	rsp_t   want_rsp;
	int     errs;
	int     cyc;

	function automatic void table_reload();
		int i;
		for (i = 0; i < MAX_SEGMENTS; i++) begin
			seg_start[i] = '0;
			seg_word[i] = '0;
		end
		seg_word[0] = init_word;
		seg_count = 1;
	endfunction

	function automatic void load_reg(logic [CFG_IDX_WIDTH-1:0] idx,
		logic [CFG_DATA_WIDTH-1:0] val);
		if (idx == REG_TOTAL_SIZE)
			tot_size = total_t'(val);
		else
			init_word = data_t'(val);
		table_reload();
	endfunction

	function automatic rsp_t seg_report(int h, status_t st);
		total_t right;
		right = (h + 1 < seg_count) ? total_t'(seg_start[h + 1]) : tot_size;
		return rsp_t'{seg_start[h], right, seg_word[h], st};
	endfunction

	// Updates the mirror and returns the beat the block should answer with.
	function automatic rsp_t apply_request(req_type_t rt, pos_t p);
		int h;
		int i;
		if ({1'b0, p} >= tot_size)
			return rsp_t'{16'h0, 17'h0, 32'h0, ST_RANGE};
		h = 0;
		for (i = 1; i < seg_count; i++)
			if (seg_start[i] <= p)
				h = i;
		case (rt)
			REQ_SPLIT: begin
				if (seg_start[h] == p)
					return seg_report(h, ST_OK);
				if (seg_count >= MAX_SEGMENTS)
					return seg_report(h, ST_FULL);
				for (i = seg_count; i > h + 1; i--) begin
					seg_start[i] = seg_start[i - 1];
					seg_word[i] = seg_word[i - 1];
				end
				seg_start[h + 1] = p;
				seg_word[h + 1] = seg_word[h];
				seg_count++;
				return seg_report(h + 1, ST_OK);
			end
			REQ_REMOVE: begin
				if (h == 0)
					return seg_report(0, ST_BASE);
				for (i = h; i + 1 < seg_count; i++) begin
					seg_start[i] = seg_start[i + 1];
					seg_word[i] = seg_word[i + 1];
				end
				seg_count--;
				seg_start[seg_count] = '0;
				seg_word[seg_count] = '0;
				return seg_report(h - 1, ST_OK);
			end
			default: return seg_report(h, ST_OK);
		endcase
	endfunction

	task automatic flag(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errs++;
	endtask

	function automatic void add_row(row_t r);
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	function automatic row_t req_row(row_kind_t kind, req_type_t rt, pos_t p, rsp_t want);
		row_t r;
		r.kind = kind;
		r.rt = rt;
		r.idx = '0;
		r.val = CFG_DATA_WIDTH'(p);
		r.want = want;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [CFG_IDX_WIDTH-1:0] idx,
		logic [CFG_DATA_WIDTH-1:0] val);
		row_t r;
		r.kind = ROW_CFG;
		r.rt = REQ_QUERY;
		r.idx = idx;
		r.val = val;
		r.want = '0;
		return r;
	endfunction

	function automatic pos_t pick_pos();
		int u;
		int lim;
		u = $urandom_range(99);
		lim = (tot_size > total_t'(65536)) ? 65536 : int'(tot_size);
		if (u < 10)
			return seg_start[$urandom_range(seg_count - 1, 0)];
		if (u < 16) begin
			if (lim < 65536)
				return pos_t'($urandom_range(65535, lim));
			return pos_t'($urandom);
		end
		if (u < 22) begin
			case ($urandom_range(2))
				0: return '0;
				1: return '1;
				default: return pos_t'(lim - 1);
			endcase
		end
		if (lim == 0)
			return pos_t'($urandom);
		return pos_t'($urandom_range(lim - 1, 0));
	endfunction

	task automatic send_item(req_type_t rt, pos_t p, bit typed, rsp_t want);
		while (!quiet && $urandom_range(99) < 17) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.pos <= p;
		want_typed = typed;
		want_rsp = want;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		load_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever @(negedge clk)
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// response beats are checked before the request beat of the same edge is queued
	always @(posedge clk) begin
		rsp_t got;
		rsp_t w;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_t'{rsp_ch.seg_left, rsp_ch.seg_right, rsp_ch.seg_data,
					rsp_ch.status};
				if (pending_rsp.size() == 0) begin
					flag("unexpected beat", 32'(got.seg_left), 32'(got.status));
				end else begin
					w = pending_rsp.pop_front();
					if (got.seg_left !== w.seg_left)
						flag("seg_left", 32'(got.seg_left), 32'(w.seg_left));
					if (got.seg_right !== w.seg_right)
						flag("seg_right", 32'(got.seg_right), 32'(w.seg_right));
					if (got.seg_data !== w.seg_data)
						flag("seg_data", got.seg_data, w.seg_data);
					if (got.status !== w.status)
						flag("status", 32'(got.status), 32'(w.status));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				w = apply_request(req_ch.req_type, req_ch.pos);
				pending_rsp.insert(pending_rsp.size(), want_typed ? want_rsp : w);
			end
		end
	end

	initial begin
		int                        ph;
		int                        n;
		int                        split_pct;
		int                        u;
		int unsigned               ph_tot [PHASES];
		int unsigned               ph_len [PHASES];
		logic [CFG_DATA_WIDTH-1:0] init_val;
		req_type_t                 rt;
		row_t                      r;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_QUERY;
		req_ch.pos = '0;
		quiet = 1'b0;
		want_typed = 1'b0;
		want_rsp = '0;
		errs = 0;
		cyc = 0;
		tot_size = TOTAL_SIZE_RESET;
		init_word = '0;
		table_reload();

		// after reset: full range, data 0
		add_row(req_row(ROW_CHK, REQ_QUERY, 16'h0000,
			rsp_t'{16'h0, 17'h10000, 32'h0, ST_OK}));
		add_row(req_row(ROW_CHK, REQ_QUERY, 16'hFFFF,
			rsp_t'{16'h0, 17'h10000, 32'h0, ST_OK}));
		add_row(req_row(ROW_CHK, REQ_REMOVE, 16'h1234,
			rsp_t'{16'h0, 17'h10000, 32'h0, ST_BASE}));
		add_row(req_row(ROW_CHK, REQ_SPLIT, 16'h0000,
			rsp_t'{16'h0, 17'h10000, 32'h0, ST_OK}));
		add_row(req_row(ROW_CHK, REQ_SPLIT, 16'h8000,
			rsp_t'{16'h8000, 17'h10000, 32'h0, ST_OK}));
		add_row(req_row(ROW_REQ, REQ_QUERY, 16'h7FFF, '0));
		add_row(req_row(ROW_REQ, REQ_SPARE, 16'h8001, '0));
		add_row(req_row(ROW_REQ, REQ_SPLIT, 16'hFFFF, '0));
		add_row(req_row(ROW_REQ, REQ_REMOVE, 16'h8000, '0));
		add_row(cfg_row(REG_INITIAL_DATA, 32'hFFFF_FFFF));
		add_row(cfg_row(REG_TOTAL_SIZE, 32'd1000));
		add_row(req_row(ROW_CHK, REQ_QUERY, 16'd1000,
			rsp_t'{16'h0, 17'h0, 32'h0, ST_RANGE}));
		add_row(req_row(ROW_CHK, REQ_SPLIT, 16'hFFFF,
			rsp_t'{16'h0, 17'h0, 32'h0, ST_RANGE}));
		add_row(req_row(ROW_CHK, REQ_QUERY, 16'd999,
			rsp_t'{16'h0, 17'd1000, 32'hFFFF_FFFF, ST_OK}));
		add_row(req_row(ROW_REQ, REQ_SPLIT, 16'd999, '0));
		add_row(req_row(ROW_REQ, REQ_SPLIT, 16'd1, '0));
		add_row(req_row(ROW_REQ, REQ_REMOVE, 16'd999, '0));
		add_row(req_row(ROW_REQ, REQ_SPARE, 16'd500, '0));
		// empty range: every position is out of range
		add_row(cfg_row(REG_TOTAL_SIZE, 32'd0));
		add_row(req_row(ROW_CHK, REQ_QUERY, 16'h0000,
			rsp_t'{16'h0, 17'h0, 32'h0, ST_RANGE}));
		// widest range: right bound beyond the last position
		add_row(cfg_row(REG_TOTAL_SIZE, 32'h1FFFF));
		add_row(req_row(ROW_CHK, REQ_SPLIT, 16'hFFFF,
			rsp_t'{16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, ST_OK}));
		add_row(cfg_row(REG_TOTAL_SIZE, 32'd1));
		add_row(req_row(ROW_CHK, REQ_SPLIT, 16'h0000,
			rsp_t'{16'h0, 17'd1, 32'hFFFF_FFFF, ST_OK}));
		add_row(req_row(ROW_CHK, REQ_REMOVE, 16'h0000,
			rsp_t'{16'h0, 17'd1, 32'hFFFF_FFFF, ST_BASE}));
		add_row(req_row(ROW_CHK, REQ_QUERY, 16'h0001,
			rsp_t'{16'h0, 17'h0, 32'h0, ST_RANGE}));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[k]) begin
			r = dir_tab[k];
			if (r.kind == ROW_CFG) begin
				settle();
				cfg_write(r.idx, r.val);
			end else begin
				send_item(r.rt, pos_t'(r.val), r.kind == ROW_CHK, r.want);
			end
		end

		ph_tot = '{32'd65536, 32'd80, 32'd1, 32'h1FFFF, $urandom_range(65535, 2), 32'd0,
			32'd65536, $urandom_range(3000, 100)};
		ph_len = '{300, 250, 60, 300, 300, 40, 400, 300};
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			quiet = (ph == 3);
			case (ph % 3)
				0: init_val = $urandom;
				1: init_val = '0;
				default: init_val = 32'hFFFF_FFFF;
			endcase
			if ($urandom_range(1)) begin
				cfg_write(REG_INITIAL_DATA, init_val);
				cfg_write(REG_TOTAL_SIZE, ph_tot[ph]);
			end else begin
				cfg_write(REG_TOTAL_SIZE, ph_tot[ph]);
				cfg_write(REG_INITIAL_DATA, init_val);
			end
			// split-heavy mixes drive the table into the full state
			split_pct = $urandom_range(55, 25);
			for (n = 0; n < ph_len[ph]; n++) begin
				u = $urandom_range(99);
				if (u < split_pct)
					rt = REQ_SPLIT;
				else if (u < split_pct + 20)
					rt = REQ_REMOVE;
				else if (u < 95)
					rt = REQ_QUERY;
				else
					rt = REQ_SPARE;
				send_item(rt, pick_pos(), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errs == 0 && pending_rsp.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ipt_pkg.sv
design/ipt_req_if.sv
design/ipt_rsp_if.sv
design/ipt_ram.sv
design/ipt_ctrl.sv
design/interval_partition_table_unit.sv
tb/sv/tb_top.sv
